FILE: rtl/core/rnsq_pkg.sv
// Shared definitions for the rotated, notched square hit test.
// Register indexes, field widths, reset values and the internal limit width.
// No dependencies.
`timescale 1ns / 1ps

package rnsq_pkg;

  // Field widths fixed by the register map.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ANGLE_W    = 16;
  localparam int LEN_W      = 15;

  // Default values for the top-level parameters.
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;

  // Reset value of the cosine register: one in Q2.14, angle zero.
  localparam logic [ANGLE_W-1:0] COS_RESET = 16'd16384;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COS_ANGLE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIN_ANGLE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_NOTCH      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP_CUT    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_CUT = 3'd7;

  // Width of the rotated coordinates and of every limit they are compared with.
  // The coordinates need the coordinate width plus twenty bits so that the sum
  // and difference of x and y cannot overflow; the limits need the fraction
  // width plus nineteen.
  function automatic int lim_width(input int coord_w, input int frac_b);
    int lw;
    lw = (coord_w + 20 > frac_b + 19) ? coord_w + 20 : frac_b + 19;
    return lw;
  endfunction

endpackage

FILE: rtl/core/rnsq_regs.sv
// Configuration registers and the figure limits derived from them.
// Depends on rnsq_pkg for register indexes, widths and the limit width.
`timescale 1ns / 1ps

module rnsq_regs #(
  parameter int COORD_WIDTH = rnsq_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rnsq_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [rnsq_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [rnsq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic signed [COORD_WIDTH-1:0]       center_x,
  output logic signed [COORD_WIDTH-1:0]       center_y,
  output logic signed [rnsq_pkg::ANGLE_W-1:0] cos_angle,
  output logic signed [rnsq_pkg::ANGLE_W-1:0] sin_angle,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] half_pos,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] half_neg,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] notch_x,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] notch_y,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] top_x,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] top_y,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] bot_xy,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] top_diag,
  output logic signed [rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS)-1:0] bot_diag,
  output logic                                top_en,
  output logic                                bot_en
);

  localparam int SW    = rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS);
  localparam int LEN_W = rnsq_pkg::LEN_W;

  logic [rnsq_pkg::CFG_DATA_W-1:0] center_x_reg;
  logic [rnsq_pkg::CFG_DATA_W-1:0] center_y_reg;
  logic [LEN_W-1:0]                side;
  logic [LEN_W-1:0]                notch;
  logic [LEN_W-1:0]                top_cut;
  logic [LEN_W-1:0]                bottom_cut;

  // Widen a length to the limit width, as a non-negative signed value.
  function automatic logic signed [SW-1:0] ext(input logic [LEN_W-1:0] v);
    logic signed [SW-1:0] r;
    r = $signed({{(SW-LEN_W){1'b0}}, v});
    return r;
  endfunction

  // Register writes; the index decodes all eight registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x_reg <= '0;
      center_y_reg <= '0;
      cos_angle    <= $signed(rnsq_pkg::COS_RESET);
      sin_angle    <= '0;
      side         <= '0;
      notch        <= '0;
      top_cut      <= '0;
      bottom_cut   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rnsq_pkg::REG_CENTER_X:   center_x_reg <= cfg_data;
        rnsq_pkg::REG_CENTER_Y:   center_y_reg <= cfg_data;
        rnsq_pkg::REG_COS_ANGLE:  cos_angle    <= $signed(cfg_data);
        rnsq_pkg::REG_SIN_ANGLE:  sin_angle    <= $signed(cfg_data);
        rnsq_pkg::REG_SIDE:       side         <= cfg_data[LEN_W-1:0];
        rnsq_pkg::REG_NOTCH:      notch        <= cfg_data[LEN_W-1:0];
        rnsq_pkg::REG_TOP_CUT:    top_cut      <= cfg_data[LEN_W-1:0];
        rnsq_pkg::REG_BOTTOM_CUT: bottom_cut   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The centre register is sixteen bits wide. A narrower coordinate keeps its
  // low bits as a signed value; a wider one sees it as a positive number.
  generate
    if (COORD_WIDTH <= rnsq_pkg::CFG_DATA_W) begin : g_center_narrow
      assign center_x = $signed(center_x_reg[COORD_WIDTH-1:0]);
      assign center_y = $signed(center_y_reg[COORD_WIDTH-1:0]);
    end else begin : g_center_wide
      assign center_x = $signed({{(COORD_WIDTH-rnsq_pkg::CFG_DATA_W){1'b0}}, center_x_reg});
      assign center_y = $signed({{(COORD_WIDTH-rnsq_pkg::CFG_DATA_W){1'b0}}, center_y_reg});
    end
  endgenerate

  // Limits at the doubled scale: a half unit is 2^FRAC_BITS, a whole unit
  // twice that. They are registered from the configuration registers.
  always_ff @(posedge clk) begin
    half_pos <= ext(side) <<< FRAC_BITS;
    half_neg <= -(ext(side) <<< FRAC_BITS);
    notch_x  <= (ext(side) <<< FRAC_BITS) - (ext(notch) <<< (FRAC_BITS + 1));
    notch_y  <= ext(notch) <<< FRAC_BITS;
    top_x    <= (ext(top_cut) <<< (FRAC_BITS + 1)) - (ext(side) <<< FRAC_BITS);
    top_y    <= (ext(side) <<< FRAC_BITS) - (ext(top_cut) <<< (FRAC_BITS + 1));
    bot_xy   <= (ext(bottom_cut) <<< (FRAC_BITS + 1)) - (ext(side) <<< FRAC_BITS);
    top_diag <= (ext(side) - ext(top_cut)) <<< (FRAC_BITS + 1);
    bot_diag <= (ext(bottom_cut) - ext(side)) <<< (FRAC_BITS + 1);
    top_en   <= (top_cut != '0);
    bot_en   <= (bottom_cut != '0);
  end

endmodule

FILE: rtl/core/rotated_notched_square_hit_test.sv
// Top level of the rotated, notched square hit test: five-stage pipeline.
// Depends on rnsq_pkg and rnsq_regs.
// Throughput: one point per cycle while res_ready is high; each stage holds one beat and a stall
// backs up stage by stage, so bubbles are squeezed out while the output waits.
// Reset: synchronous; empties the pipeline and restores the register defaults.
`timescale 1ns / 1ps

module rotated_notched_square_hit_test #(
  parameter int COORD_WIDTH = rnsq_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rnsq_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rnsq_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [rnsq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            point_valid,
  output logic                            point_ready,
  input  logic signed [COORD_WIDTH-1:0]   point_x,
  input  logic signed [COORD_WIDTH-1:0]   point_y,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            inside_res
);

  localparam int SW     = rnsq_pkg::lim_width(COORD_WIDTH, FRAC_BITS);
  localparam int DW     = COORD_WIDTH + 1;
  localparam int PW     = DW + rnsq_pkg::ANGLE_W;
  localparam int STAGES = 5;

  logic signed [COORD_WIDTH-1:0]       center_x;
  logic signed [COORD_WIDTH-1:0]       center_y;
  logic signed [rnsq_pkg::ANGLE_W-1:0] cos_angle;
  logic signed [rnsq_pkg::ANGLE_W-1:0] sin_angle;
  logic signed [SW-1:0] half_pos;
  logic signed [SW-1:0] half_neg;
  logic signed [SW-1:0] notch_x;
  logic signed [SW-1:0] notch_y;
  logic signed [SW-1:0] top_x;
  logic signed [SW-1:0] top_y;
  logic signed [SW-1:0] bot_xy;
  logic signed [SW-1:0] top_diag;
  logic signed [SW-1:0] bot_diag;
  logic                 top_en;
  logic                 bot_en;

  rnsq_regs #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .center_x  (center_x),
    .center_y  (center_y),
    .cos_angle (cos_angle),
    .sin_angle (sin_angle),
    .half_pos  (half_pos),
    .half_neg  (half_neg),
    .notch_x   (notch_x),
    .notch_y   (notch_y),
    .top_x     (top_x),
    .top_y     (top_y),
    .bot_xy    (bot_xy),
    .top_diag  (top_diag),
    .bot_diag  (bot_diag),
    .top_en    (top_en),
    .bot_en    (bot_en)
  );

  // Stage valid bits and per-stage ready: a stage takes a new beat when it is
  // empty or when the stage after it takes its beat.
  logic [STAGES:1]   valid;
  logic [STAGES+1:1] rdy;

  always_comb begin
    rdy[STAGES+1] = res_ready;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign point_ready = rdy[1];
  assign res_valid   = valid[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[1]) begin
        valid[1] <= point_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Stage 1: translate the point by the centre.
  logic signed [DW-1:0] dx1;
  logic signed [DW-1:0] dy1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dx1 <= DW'(point_x) - DW'(center_x);
      dy1 <= DW'(point_y) - DW'(center_y);
    end
  end

  // Stage 2: the four rotation products.
  logic signed [PW-1:0] dx_cos2;
  logic signed [PW-1:0] dy_sin2;
  logic signed [PW-1:0] dy_cos2;
  logic signed [PW-1:0] dx_sin2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dx_cos2 <= PW'(dx1) * PW'(cos_angle);
      dy_sin2 <= PW'(dy1) * PW'(sin_angle);
      dy_cos2 <= PW'(dy1) * PW'(cos_angle);
      dx_sin2 <= PW'(dx1) * PW'(sin_angle);
    end
  end

  // Stage 3: rotated coordinates at the doubled scale.
  logic signed [SW-1:0] x3;
  logic signed [SW-1:0] y3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      x3 <= (SW'(dx_cos2) + SW'(dy_sin2)) <<< 1;
      y3 <= (SW'(dy_cos2) - SW'(dx_sin2)) <<< 1;
    end
  end

  // Stage 4: bound, notch and corner-region compares, plus the diagonal sums.
  logic                 outside4;
  logic                 notch4;
  logic                 top_zone4;
  logic                 bot_zone4;
  logic signed [SW-1:0] y_minus_x4;
  logic signed [SW-1:0] x_plus_y4;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      outside4   <= (x3 > half_pos) || (x3 < half_neg) ||
                    (y3 > half_pos) || (y3 < half_neg);
      notch4     <= (x3 > notch_x) && (y3 > -notch_y) && (y3 < notch_y);
      top_zone4  <= top_en && (x3 >= half_neg) && (x3 <= top_x) &&
                    (y3 >= top_y) && (y3 <= half_pos);
      bot_zone4  <= bot_en && (x3 >= half_neg) && (x3 <= bot_xy) &&
                    (y3 >= half_neg) && (y3 <= bot_xy);
      y_minus_x4 <= y3 - x3;
      x_plus_y4  <= x3 + y3;
    end
  end

  // Stage 5: corner diagonal tests and the final verdict.
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      inside_res <= !outside4 && !notch4 &&
                    !(top_zone4 && (y_minus_x4 > top_diag)) &&
                    !(bot_zone4 && (x_plus_y4 < bot_diag));
    end
  end

endmodule

FILE: dv/rotated_notched_square_hit_test_tb.sv
// Self-checking testbench for the rotated, notched square hit test.
// A directed table runs first, then random phases with fresh register settings.
// Depends on rnsq_pkg and the rotated_notched_square_hit_test top level.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_W          = 16;
  localparam int FRAC             = 14;
  localparam int LIMIT_CYCLES     = 600000;
  localparam int RANDOM_PHASES    = 9;
  localparam int POINTS_PER_PHASE = 134;

  // One row of the directed table: either a register write or a point.
  typedef enum bit {ROW_POINT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                             kind;
    logic [rnsq_pkg::CFG_ADDR_W-1:0]       idx;
    logic [rnsq_pkg::CFG_DATA_W-1:0]       data;
    logic signed [COORD_W-1:0]             px;
    logic signed [COORD_W-1:0]             py;
    bit                                    known;
    bit                                    want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 39;

  // Expected values are typed in only for the rows that are obvious by hand.
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // Register defaults: zero side, so only the centre is inside.
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd0, 16'sd0, 1'b1, 1'b1},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd1, 16'sd0, 1'b1, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sh8000, 16'sh8000, 1'b1, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd0, -16'sd1, 1'b1, 1'b0},
    // Plain square of side 100: the outer edges are inclusive.
    '{ROW_WRITE, rnsq_pkg::REG_SIDE, 16'd100, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd50, 16'sd50, 1'b1, 1'b1},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd51, 16'sd0, 1'b1, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, -16'sd50, -16'sd50, 1'b1, 1'b1},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd0, -16'sd51, 1'b1, 1'b0},
    // Right-edge notch of 20: strict on y, its inner x bound kept.
    '{ROW_WRITE, rnsq_pkg::REG_NOTCH, 16'd20, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd45, 16'sd0, 1'b1, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd45, 16'sd10, 1'b1, 1'b1},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd30, 16'sd0, 1'b1, 1'b1},
    // Top-left corner cut of 20: the hypotenuse itself stays inside.
    '{ROW_WRITE, rnsq_pkg::REG_TOP_CUT, 16'd20, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, -16'sd50, 16'sd50, 1'b1, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, -16'sd40, 16'sd40, 1'b1, 1'b1},
    // Bottom-left corner cut of 20.
    '{ROW_WRITE, rnsq_pkg::REG_BOTTOM_CUT, 16'd20, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, -16'sd50, -16'sd50, 1'b1, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, -16'sd40, -16'sd40, 1'b1, 1'b1},
    // Quarter turn, so the notch now faces along y.
    '{ROW_WRITE, rnsq_pkg::REG_COS_ANGLE, 16'd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_SIN_ANGLE, 16'd16384, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd0, 16'sd45, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd0, -16'sd45, 1'b0, 1'b0},
    // Cosine and sine off the unit circle scale the rotated point.
    '{ROW_WRITE, rnsq_pkg::REG_COS_ANGLE, 16'd16384, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd30, 16'sd10, 1'b0, 1'b0},
    // Every register at an extreme; the side write also sets the ignored top bit.
    '{ROW_WRITE, rnsq_pkg::REG_CENTER_X, 16'h8000, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_CENTER_Y, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_COS_ANGLE, 16'hC000, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_SIN_ANGLE, 16'hC000, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_SIDE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_NOTCH, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_TOP_CUT, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, rnsq_pkg::REG_BOTTOM_CUT, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, -16'sd1, -16'sd1, 1'b0, 1'b0},
    '{ROW_POINT, rnsq_pkg::REG_CENTER_X, 16'd0, 16'sh8000, 16'sh8000, 1'b0, 1'b0}
  };

  // Rotation choices for the random phases; the last two lie off the unit circle.
  localparam logic signed [15:0] ANGLE_COS [0:11] = '{
    16384, 0, -16384, 0, 11585, 11585, -11585, 14189, 8192, -14189, 16384, -16384
  };
  localparam logic signed [15:0] ANGLE_SIN [0:11] = '{
    0, 16384, 0, -16384, 11585, -11585, 11585, 8192, -14189, -8192, 16384, -16384
  };

  logic                                  clk;
  logic                                  rst;
  logic                                  cfg_wr_en;
  logic [rnsq_pkg::CFG_ADDR_W-1:0]       cfg_index;
  logic [rnsq_pkg::CFG_DATA_W-1:0]       cfg_data;
  logic                                  point_valid;
  logic                                  point_ready;
  logic signed [COORD_W-1:0]             point_x;
  logic signed [COORD_W-1:0]             point_y;
  logic                                  res_valid;
  logic                                  res_ready;
  logic                                  inside_res;

  // Shadow copy of the figure registers, kept in step with every write.
  logic signed [15:0]                    ctr_x, ctr_y, cos_q, sin_q;
  logic [rnsq_pkg::LEN_W-1:0]            side_len, notch_len, top_cut, bot_cut;

  bit                                    expected_inside[$];
  int unsigned                           mismatch_count;
  int unsigned                           results_seen;
  int unsigned                           idle_odds;
  bit                                    want_bit;

  rotated_notched_square_hit_test #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .inside_res (inside_res)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Exact hit test on the shadow registers, at twice the Q2.14 scale.
  function automatic bit predict_inside(input logic signed [15:0] px,
                                        input logic signed [15:0] py);
    longint c, s, a, a1, a2, a3, half_u, unit, dx, dy, x, y, h;
    c      = cos_q;
    s      = sin_q;
    a      = side_len;
    a1     = notch_len;
    a2     = top_cut;
    a3     = bot_cut;
    half_u = longint'(1) << FRAC;
    unit   = 2 * half_u;
    dx     = longint'(px) - longint'(ctr_x);
    dy     = longint'(py) - longint'(ctr_y);
    x      = (dx * c + dy * s) * 2;
    y      = (dy * c - dx * s) * 2;
    h      = a * half_u;
    if (x > h || x < -h || y > h || y < -h)
      return 1'b0;
    if (x > h - a1 * unit && -(a1 * half_u) < y && y < a1 * half_u)
      return 1'b0;
    if (a2 > 0 && x >= -h && x <= -h + a2 * unit && y >= h - a2 * unit && y <= h &&
        y - x > (a - a2) * unit)
      return 1'b0;
    if (a3 > 0 && x >= -h && x <= -h + a3 * unit && y >= -h && y <= -h + a3 * unit &&
        x + y < (a3 - a) * unit)
      return 1'b0;
    return 1'b1;
  endfunction

  // Saturate a coordinate to the signed 16-bit range of the point fields.
  function automatic logic signed [15:0] to_coord(input int v);
    if (v > 32767)
      return 16'sh7FFF;
    if (v < -32768)
      return 16'sh8000;
    return v[15:0];
  endfunction

  // Notch or cut length: mostly within the side, sometimes zero or oversized.
  function automatic logic [15:0] pick_cut(input int a);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0)
      return 16'd0;
    if (r == 1)
      return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, a));
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Stop offering points and wait until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk);
    point_valid = 1'b0;
    while (expected_inside.size() != 0)
      @(negedge clk);
  endtask

  // One register write, mirrored in the shadow copy.
  task automatic write_reg(input logic [rnsq_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      rnsq_pkg::REG_CENTER_X:   ctr_x     = data;
      rnsq_pkg::REG_CENTER_Y:   ctr_y     = data;
      rnsq_pkg::REG_COS_ANGLE:  cos_q     = data;
      rnsq_pkg::REG_SIN_ANGLE:  sin_q     = data;
      rnsq_pkg::REG_SIDE:       side_len  = data[rnsq_pkg::LEN_W-1:0];
      rnsq_pkg::REG_NOTCH:      notch_len = data[rnsq_pkg::LEN_W-1:0];
      rnsq_pkg::REG_TOP_CUT:    top_cut   = data[rnsq_pkg::LEN_W-1:0];
      rnsq_pkg::REG_BOTTOM_CUT: bot_cut   = data[rnsq_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Offer one point, with an optional gap first, and log its expected result.
  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                            input bit known, input bit want);
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      point_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    point_x     = px;
    point_y     = py;
    point_valid = 1'b1;
    do
      @(posedge clk);
    while (!point_ready);
    expected_inside.push_back(known ? want : predict_inside(px, py));
  endtask

  // Register settings for one random phase; the first two set extreme values.
  task automatic configure_phase(input int ph);
    logic [15:0] cx, cy, cv, sv, av, nv, tv, bv;
    int k;
    int a_int;
    if (ph == 0) begin
      cx = 16'h7FFF;
      cy = 16'h8000;
      cv = 16'h4000;
      sv = 16'hC000;
      av = 16'h7FFF;
      nv = 16'h7FFF;
      tv = 16'h7FFF;
      bv = 16'h7FFF;
    end else if (ph == 1) begin
      cx = 16'($urandom_range(0, 200) - 100);
      cy = 16'($urandom_range(0, 200) - 100);
      cv = 16'hC000;
      sv = 16'd0;
      av = 16'd0;
      nv = 16'd0;
      tv = 16'd0;
      bv = 16'd0;
    end else begin
      k = $urandom_range(0, 14);
      if (k < 12) begin
        cv = ANGLE_COS[k];
        sv = ANGLE_SIN[k];
      end else begin
        cv = 16'($urandom_range(0, 32768) - 16384);
        sv = 16'($urandom_range(0, 32768) - 16384);
      end
      if ($urandom_range(0, 4) == 0) begin
        cx = 16'($urandom);
        cy = 16'($urandom);
      end else begin
        cx = 16'($urandom_range(0, 4000) - 2000);
        cy = 16'($urandom_range(0, 4000) - 2000);
      end
      k = $urandom_range(0, 9);
      if (k == 0)
        a_int = $urandom_range(0, 32767);
      else if (k == 1)
        a_int = $urandom_range(0, 3);
      else
        a_int = $urandom_range(4, 400);
      av = 16'(a_int);
      nv = pick_cut(a_int);
      tv = pick_cut(a_int);
      bv = pick_cut(a_int);
    end
    write_reg(rnsq_pkg::REG_CENTER_X, cx);
    write_reg(rnsq_pkg::REG_CENTER_Y, cy);
    write_reg(rnsq_pkg::REG_COS_ANGLE, cv);
    write_reg(rnsq_pkg::REG_SIN_ANGLE, sv);
    write_reg(rnsq_pkg::REG_SIDE, av);
    write_reg(rnsq_pkg::REG_NOTCH, nv);
    write_reg(rnsq_pkg::REG_TOP_CUT, tv);
    write_reg(rnsq_pkg::REG_BOTTOM_CUT, bv);
  endtask

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        res_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      res_ready = !rst;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_inside.size() == 0) begin
        flag_mismatch("result beat with no point outstanding");
      end else begin
        want_bit = expected_inside.pop_front();
        if (inside_res !== want_bit)
          flag_mismatch($sformatf("result %0d: inside_res %b, expected %b",
                                  results_seen, inside_res, want_bit));
      end
      results_seen++;
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, final drain.
  initial begin
    logic signed [15:0] px, py;
    int span;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = rnsq_pkg::REG_CENTER_X;
    cfg_data       = '0;
    point_valid    = 1'b0;
    point_x        = '0;
    point_y        = '0;
    mismatch_count = 0;
    results_seen   = 0;
    idle_odds      = 5;
    ctr_x          = '0;
    ctr_y          = '0;
    cos_q          = rnsq_pkg::COS_RESET;
    sin_q          = '0;
    side_len       = '0;
    notch_len      = '0;
    top_cut        = '0;
    bot_cut        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_point(DIRECTED[i].px, DIRECTED[i].py, DIRECTED[i].known, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      // Every third phase, and the closing one, runs at full rate.
      if (ph == RANDOM_PHASES - 1 || ph % 3 == 2)
        idle_odds = 0;
      else
        idle_odds = 3 + ph % 4;
      configure_phase(ph);
      span = side_len / 2 + side_len / 8 + 3;
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        // Hold the sender once mid-stream until the pipeline has emptied.
        if (ph == 3 && n == POINTS_PER_PHASE / 2)
          drain_results();
        if ($urandom_range(0, 9) == 0) begin
          px = 16'($urandom);
          py = 16'($urandom);
        end else begin
          px = to_coord(int'(ctr_x) + int'($urandom_range(0, 2 * span)) - span);
          py = to_coord(int'(ctr_y) + int'($urandom_range(0, 2 * span)) - span);
        end
        send_point(px, py, 1'b0, 1'b0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rnsq_pkg.sv
rtl/core/rnsq_regs.sv
rtl/core/rotated_notched_square_hit_test.sv
dv/rotated_notched_square_hit_test_tb.sv
